/* sv/ffect_pkg.sv */
// ----------------------------------------------------------------------------
// Far-field edge terms package
// Shared widths, constants, records and fixed-point helpers for the block.
// ----------------------------------------------------------------------------
package ffect_pkg;

    localparam int RAD_W    = 66;
    localparam int ROOT_W   = 33;
    localparam int SQ_STEPS = 33;

    localparam logic [30:0]        M_ONE    = 31'h4000_0000;
    localparam logic signed [13:0] HUGE_N   = 14'sd4096;
    localparam logic [126:0]       DIAG_LIM = 127'h7FFF_FFFF;
    localparam logic [126:0]       CP_LIM   = 127'd1 << 62;
    localparam logic [31:0]        Q_POS    = 32'h7FFF_FFFF;
    localparam logic [31:0]        Q_NEG    = 32'h8000_0000;

    typedef logic [31:0] root_tab_t [16];

    typedef struct packed {
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] f1;
        logic signed [31:0] f2;
        logic signed [15:0] e;
    } side_t;

    // A power-of-two scaling split into a shift half and a clamp half.
    typedef struct packed {
        logic [126:0] w;
        logic         big;
    } scl_t;

    typedef struct packed {
        logic [62:0] val;
        logic        sat;
    } sres_t;

    typedef struct packed {
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] f1;
        logic signed [31:0] f2;
        logic signed [15:0] e;
        logic [32:0]        len;
        logic [31:0]        mid_dist;
        logic [4:0]         pidx;
        logic [31:0]        x;
        logic [15:0]        frac;
        logic signed [13:0] n;
        logic [15:0]        f;
        logic [30:0]        m;
        logic               flag;
        logic [63:0]        lm;
        logic [63:0]        a1;
        logic [63:0]        a2;
        scl_t               sd_s;
        scl_t               s1_s;
        scl_t               s2_s;
        logic [31:0]        diag;
        logic [62:0]        cp1;
        logic [62:0]        cp2;
        logic               ng1;
        logic               ng2;
        logic [62:0]        dm1;
        logic [62:0]        dm2;
        logic [64:0]        pl1;
        logic [64:0]        pl2;
        logic [63:0]        ph1;
        logic [63:0]        ph2;
        logic [31:0]        r1;
        logic [31:0]        r2;
    } item_t;

    // Integer square root, used only while building the root table.
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    // Successive square roots of two in Q1.30: entry i is 2^(2^(i-16)).
    function automatic root_tab_t make_roots();
        root_tab_t   t;
        logic [63:0] r;
        r = isqrt64(64'd1 << 61);
        t[15] = r[31:0];
        for (int i = 15; i > 0; i--)
        begin
            r = isqrt64({2'b00, t[i], 30'd0});
            t[i-1] = r[31:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = make_roots();

    function automatic scl_t scale_shift(logic [63:0] v, logic signed [14:0] s);
        scl_t        r;
        logic [14:0] ns;
        r.w   = '0;
        r.big = 1'b0;
        ns    = -s;
        if (v != '0)
        begin
            if (!s[14])
            begin
                if (s >= 15'sd63)
                    r.big = 1'b1;
                else
                    r.w = {63'd0, v} << s[5:0];
            end
            else if (s > -15'sd64)
            begin
                r.w = {63'd0, v >> ns[5:0]};
            end
        end
        return r;
    endfunction

    function automatic sres_t scale_clamp(scl_t a, logic [126:0] lim);
        sres_t r;
        r.sat = a.big || (a.w > lim);
        r.val = r.sat ? lim[62:0] : a.w[62:0];
        return r;
    endfunction

endpackage

/* sv/ffect_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 66-bit radicand, one result bit per register stage.
// ----------------------------------------------------------------------------
module ffect_isqrt
    import ffect_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [ROOT_W+1:0] rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg [SQ_STEPS];
    logic [RAD_W-1:0]  rad_reg  [SQ_STEPS];
    logic [ROOT_W+1:0] rem_next  [SQ_STEPS];
    logic [ROOT_W-1:0] root_next [SQ_STEPS];
    logic [RAD_W-1:0]  rad_next  [SQ_STEPS];

    always_comb
    begin
        logic [ROOT_W+1:0] rin;
        logic [ROOT_W-1:0] qin;
        logic [RAD_W-1:0]  din;
        logic [ROOT_W+3:0] cur;
        logic [ROOT_W+3:0] trial;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                rin = '0;
                qin = '0;
                din = rad;
            end
            else
            begin
                rin = rem_reg[k-1];
                qin = root_reg[k-1];
                din = rad_reg[k-1];
            end
            cur   = {rin, din[RAD_W-1:RAD_W-2]};
            trial = {2'b00, qin, 2'b01};
            rad_next[k] = {din[RAD_W-3:0], 2'b00};
            if (cur >= trial)
            begin
                rem_next[k]  = (ROOT_W+2)'(cur - trial);
                root_next[k] = {qin[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = cur[ROOT_W+1:0];
                root_next[k] = {qin[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule

/* sv/farfield_edge_condition_terms.sv */
// ----------------------------------------------------------------------------
// Far-field edge condition terms
// Lumped diagonal and right-hand-side terms for one two-node boundary edge.
// ----------------------------------------------------------------------------
// The block takes one edge word per cycle unless stalled and returns one result
// word for each, in order. Most of the pipeline depth lies in
// the two 33-step square-root pipelines (edge length and midpoint distance),
// the 16 squaring steps of the base-two logarithm and the 16 conditional
// multiplies that rebuild the fractional power. Every stage is a register stage,
// so the sustained rate is one word per clock unless back-pressure stalls it.
// A stall at the output halts the whole pipeline only when the last stage
// also holds a word; an empty last stage lets the pipeline keep moving behind a waiting result.
module farfield_edge_condition_terms
    import ffect_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, second_x, second_y, first_potential,
    // second_potential, field_first, field_second, decay_exponent
    input  logic [271:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // diag_term, rhs_first, rhs_second
    output logic [95:0]  m_tdata,
    // overflow_flag
    output logic         m_tuser
);

    localparam int NFRONT  = 4;
    localparam int NPOST   = 40;
    localparam int NV      = NFRONT + SQ_STEPS + NPOST;
    localparam int K_NORM  = 0;
    localparam int K_EXP   = 17;
    localparam int K_PROD  = 34;
    localparam int K_SHIFT = 35;
    localparam int K_CLAMP = 36;
    localparam int K_DIFF  = 37;
    localparam int K_PART  = 38;

    // Stage control: the pipeline moves unless a held result would be overrun.
    logic          adv;
    logic [NV-1:0] vld_reg;
    logic [NV-1:0] vld_next;
    logic          out_vld_reg;
    logic          out_vld_next;

    // Front stages: operand capture, magnitudes, squares, sums of squares.
    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    side_t              side0_reg, side1_reg, side2_reg, side3_reg;
    logic [32:0]        adx_reg, ady_reg, asx_reg, asy_reg;
    logic [65:0]        qdx_reg, qdy_reg, qsx_reg, qsy_reg;
    logic [RAD_W-1:0]   radl_reg, radd_reg;
    side_t              sline_reg [SQ_STEPS];
    logic [ROOT_W-1:0]  root_l, root_d;

    item_t src;
    item_t pipe_reg  [NPOST];
    item_t pipe_next [NPOST];

    logic [31:0] out_diag_reg, out_r1_reg, out_r2_reg;
    logic        out_flag_reg;

    function automatic logic [32:0] mag33(logic signed [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [4:0] top_bit(logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                r = 5'(i);
        end
        return r;
    endfunction

    function automatic item_t step_norm(item_t a);
        item_t      r;
        logic [4:0] p;
        r = a;
        p = top_bit(a.mid_dist);
        r.pidx = p;
        r.x    = a.mid_dist << (5'd31 - p);
        r.frac = '0;
        return r;
    endfunction

    // One squaring step of the logarithm yields one fraction bit.
    function automatic item_t step_log(item_t a);
        item_t       r;
        logic [63:0] sq;
        logic [32:0] y;
        r  = a;
        sq = {32'd0, a.x} * {32'd0, a.x};
        y  = sq[63:31];
        r.x    = y[32] ? y[32:1] : y[31:0];
        r.frac = {a.frac[14:0], y[32]};
        return r;
    endfunction

    // Negated exponent times log, split into an integer shift and a 16-bit fraction.
    function automatic item_t step_exp(item_t a);
        item_t              r;
        logic signed [16:0] ne;
        logic signed [20:0] lv;
        logic signed [37:0] prod;
        r    = a;
        ne   = -($signed({a.e[15], a.e}));
        lv   = $signed({~a.pidx[4], a.pidx[3:0], a.frac});
        prod = ne * lv;
        r.m  = M_ONE;
        r.n  = prod[37:24];
        r.f  = prod[23:8];
        if (a.e == '0)
        begin
            r.m = '0;
            r.n = '0;
            r.f = '0;
        end
        else if (a.mid_dist == '0)
        begin
            r.flag = 1'b1;
            r.f    = '0;
            if (!a.e[15])
            begin
                r.m = M_ONE;
                r.n = HUGE_N;
            end
            else
            begin
                r.m = '0;
                r.n = '0;
            end
        end
        return r;
    endfunction

    function automatic item_t step_root(item_t a, logic [3:0] i);
        item_t       r;
        logic [62:0] mp;
        r  = a;
        mp = a.m * ROOT_TAB[i];
        if (a.f[i])
            r.m = mp[60:30];
        return r;
    endfunction

    function automatic item_t step_prod(item_t a);
        item_t r;
        r    = a;
        r.lm = a.len * a.m;
        r.a1 = mag32(a.p1) * a.m;
        r.a2 = mag32(a.p2) * a.m;
        return r;
    endfunction

    function automatic item_t step_shift(item_t a);
        item_t              r;
        logic signed [14:0] sd;
        logic signed [14:0] sc;
        r  = a;
        sd = $signed({a.n[13], a.n}) - 15'sd31;
        sc = $signed({a.n[13], a.n}) - 15'sd30;
        r.sd_s = scale_shift(a.lm, sd);
        r.s1_s = scale_shift(a.a1, sc);
        r.s2_s = scale_shift(a.a2, sc);
        return r;
    endfunction

    function automatic item_t step_clamp(item_t a);
        item_t r;
        sres_t rd, c1, c2;
        r  = a;
        rd = scale_clamp(a.sd_s, DIAG_LIM);
        c1 = scale_clamp(a.s1_s, CP_LIM);
        c2 = scale_clamp(a.s2_s, CP_LIM);
        r.diag = rd.val[31:0];
        r.cp1  = c1.val;
        r.cp2  = c2.val;
        r.flag = a.flag | rd.sat | c1.sat | c2.sat;
        return r;
    endfunction

    // Field minus signed coefficient product, as sign and magnitude.
    function automatic logic [63:0] diff_of(logic signed [31:0] fv,
                                            logic signed [31:0] pv,
                                            logic [62:0] cp);
        logic signed [64:0] cps;
        logic signed [64:0] dif;
        logic [64:0]        mg;
        cps = pv[31] ? -$signed({2'b00, cp}) : $signed({2'b00, cp});
        dif = $signed({{33{fv[31]}}, fv}) - cps;
        mg  = dif[64] ? 65'(-dif) : dif;
        return {dif[64], mg[62:0]};
    endfunction

    function automatic item_t step_diff(item_t a);
        item_t       r;
        logic [63:0] d1, d2;
        r  = a;
        d1 = diff_of(a.f1, a.p1, a.cp1);
        d2 = diff_of(a.f2, a.p2, a.cp2);
        r.ng1 = d1[63];
        r.dm1 = d1[62:0];
        r.ng2 = d2[63];
        r.dm2 = d2[62:0];
        return r;
    endfunction

    function automatic item_t step_part(item_t a);
        item_t r;
        r     = a;
        r.pl1 = a.dm1[31:0] * a.len;
        r.ph1 = a.dm1[62:32] * a.len;
        r.pl2 = a.dm2[31:0] * a.len;
        r.ph2 = a.dm2[62:32] * a.len;
        return r;
    endfunction

    // Halve the length product into Q16.16 toward zero and saturate.
    function automatic logic [32:0] fin_of(logic [64:0] pl, logic [63:0] ph,
                                           logic ng);
        logic [96:0] prod;
        logic [63:0] q;
        logic [31:0] r;
        logic        sat;
        prod = {32'd0, pl} + {1'b0, ph, 32'd0};
        q    = prod[80:17];
        sat  = 1'b0;
        if (prod[96:81] != '0)
        begin
            sat = 1'b1;
            r   = ng ? Q_NEG : Q_POS;
        end
        else if (ng)
        begin
            if (q > {32'd0, Q_NEG})
            begin
                sat = 1'b1;
                r   = Q_NEG;
            end
            else
            begin
                r = ~q[31:0] + 32'd1;
            end
        end
        else if (q > {32'd0, Q_POS})
        begin
            sat = 1'b1;
            r   = Q_POS;
        end
        else
        begin
            r = q[31:0];
        end
        return {sat, r};
    endfunction

    function automatic item_t step_fin(item_t a);
        item_t       r;
        logic [32:0] o1, o2;
        r  = a;
        o1 = fin_of(a.pl1, a.ph1, a.ng1);
        o2 = fin_of(a.pl2, a.ph2, a.ng2);
        r.r1   = o1[31:0];
        r.r2   = o2[31:0];
        r.flag = a.flag | o1[32] | o2[32];
        return r;
    endfunction

    function automatic item_t post_step(int k, item_t a);
        item_t r;
        if (k == K_NORM)
            r = step_norm(a);
        else if (k < K_EXP)
            r = step_log(a);
        else if (k == K_EXP)
            r = step_exp(a);
        else if (k < K_PROD)
            r = step_root(a, 4'(K_PROD - 1 - k));
        else if (k == K_PROD)
            r = step_prod(a);
        else if (k == K_SHIFT)
            r = step_shift(a);
        else if (k == K_CLAMP)
            r = step_clamp(a);
        else if (k == K_DIFF)
            r = step_diff(a);
        else if (k == K_PART)
            r = step_part(a);
        else
            r = step_fin(a);
        return r;
    endfunction

    // The input side is ready whenever the pipeline may advance.
    assign adv      = m_tready || !out_vld_reg || !vld_reg[NV-1];
    assign s_tready = adv;

    assign vld_next     = adv ? {vld_reg[NV-2:0], s_tvalid} : vld_reg;
    assign out_vld_next = (vld_reg[NV-1] && adv) || (out_vld_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Front end: differences and sums of the node coordinates, then squares.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg       <= s_tdata[31:0];
            y1_reg       <= s_tdata[63:32];
            x2_reg       <= s_tdata[95:64];
            y2_reg       <= s_tdata[127:96];
            side0_reg.p1 <= s_tdata[159:128];
            side0_reg.p2 <= s_tdata[191:160];
            side0_reg.f1 <= s_tdata[223:192];
            side0_reg.f2 <= s_tdata[255:224];
            side0_reg.e  <= s_tdata[271:256];

            adx_reg   <= mag33(33'(x2_reg) - 33'(x1_reg));
            ady_reg   <= mag33(33'(y2_reg) - 33'(y1_reg));
            asx_reg   <= mag33(33'(x1_reg) + 33'(x2_reg));
            asy_reg   <= mag33(33'(y1_reg) + 33'(y2_reg));
            side1_reg <= side0_reg;

            qdx_reg   <= adx_reg * adx_reg;
            qdy_reg   <= ady_reg * ady_reg;
            qsx_reg   <= asx_reg * asx_reg;
            qsy_reg   <= asy_reg * asy_reg;
            side2_reg <= side1_reg;

            radl_reg  <= qdx_reg + qdy_reg;
            radd_reg  <= qsx_reg + qsy_reg;
            side3_reg <= side2_reg;

            sline_reg[0] <= side3_reg;
            for (int j = 1; j < SQ_STEPS; j++)
                sline_reg[j] <= sline_reg[j-1];
        end
    end

    ffect_isqrt u_len_sqrt
    (
        .clk  (clk),
        .en   (adv),
        .rad  (radl_reg),
        .root (root_l)
    );

    ffect_isqrt u_dist_sqrt
    (
        .clk  (clk),
        .en   (adv),
        .rad  (radd_reg),
        .root (root_d)
    );

    // The midpoint distance is half the root of the summed coordinates.
    always_comb
    begin
        src          = '0;
        src.p1       = sline_reg[SQ_STEPS-1].p1;
        src.p2       = sline_reg[SQ_STEPS-1].p2;
        src.f1       = sline_reg[SQ_STEPS-1].f1;
        src.f2       = sline_reg[SQ_STEPS-1].f2;
        src.e        = sline_reg[SQ_STEPS-1].e;
        src.len      = root_l;
        src.mid_dist = root_d[ROOT_W-1:1];
    end

    always_comb
    begin
        for (int k = 0; k < NPOST; k++)
        begin
            if (k == 0)
                pipe_next[k] = post_step(k, src);
            else
                pipe_next[k] = post_step(k, pipe_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NPOST; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    // Output register: loads only when a finished word arrives behind it.
    always_ff @(posedge clk)
    begin
        if (vld_reg[NV-1] && adv)
        begin
            out_diag_reg <= pipe_reg[NPOST-1].diag;
            out_r1_reg   <= pipe_reg[NPOST-1].r1;
            out_r2_reg   <= pipe_reg[NPOST-1].r2;
            out_flag_reg <= pipe_reg[NPOST-1].flag;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_r2_reg, out_r1_reg, out_diag_reg};
    assign m_tuser  = out_flag_reg;

endmodule

/* sv/ffect_checker.sv */
// ----------------------------------------------------------------------------
// Far-field edge terms port checker
// Watches the stream ports of the block over time.
// ----------------------------------------------------------------------------
module ffect_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    // A waiting result word is held until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // The input side only stalls behind a result that is not being taken.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // The lumped diagonal entry is a nonnegative coefficient times a length.
    a_diag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[31])
        else $error("negative diagonal entry");

endmodule

bind farfield_edge_condition_terms ffect_checker u_ffect_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
